/* hdl/assert_macros.svh */
// assertion macros shared by the converter modules
// no dependencies; included by the files that carry assertions
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define I2A_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// condition must never be seen at a clock edge outside reset
`define I2A_ASSERT_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

/* hdl/i2a_pkg.sv */
// shared types, codes and helpers for the integer to ascii converter
// no dependencies; imported by every module of the block
package i2a_pkg;

   // default conversion width
   localparam int unsigned VALUE_WIDTH_DEF = 32;

   // mode codes
   localparam logic [1:0] OP_SDEC = 2'd0;
   localparam logic [1:0] OP_UDEC = 2'd1;
   localparam logic [1:0] OP_OCT  = 2'd2;
   localparam logic [1:0] OP_HEX  = 2'd3;

   // character codes
   localparam logic [6:0] CHAR_MINUS      = 7'h2D;
   localparam logic [6:0] CHAR_HASH       = 7'h23;
   localparam logic [6:0] CHAR_ZERO       = 7'h30;
   localparam logic [6:0] CHAR_ALPHA_BASE = 7'h57;

   // request and response payloads
   typedef struct packed {
      logic [1:0]  op;
      logic [31:0] value;
   } i2a_req_type;

   typedef struct packed {
      logic [6:0] char_code;
      logic       last;
   } i2a_rsp_type;

   // controller to datapath commands
   typedef struct packed {
      logic load;
      logic conv_step;
      logic skip_shift;
      logic emit_prefix;
      logic emit_digit;
   } i2a_cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic conv_done;
      logic top_zero;
      logic cnt_one;
      logic has_prefix;
      logic prefix_last;
      logic out_free;
   } i2a_sts_type;

   // digit value to lowercase ascii
   function automatic logic [6:0] digit_char(input logic [3:0] d);
      logic [6:0] dx;
      dx = {3'b000, d};
      digit_char = (d <= 4'd9) ? (CHAR_ZERO + dx) : (CHAR_ALPHA_BASE + dx);
   endfunction

endpackage

/* hdl/i2a_ctrl.sv */
// sequencing state machine of the integer to ascii converter
// depends on i2a_pkg and assert_macros.svh
`include "assert_macros.svh"

module i2a_ctrl
   import i2a_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  i2a_sts_type sts,
   output i2a_cmd_type cmd
);

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_CONV   = 5'b00010,
      ST_SKIP   = 5'b00100,
      ST_PREFIX = 5'b01000,
      ST_DIGITS = 5'b10000
   } state_type;

   state_type state_ff;
   state_type state_in;

   // next state and command decode
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_CONV;
            end
         end
         ST_CONV: begin
            if (sts.conv_done) begin
               state_in = ST_SKIP;
            end else begin
               cmd.conv_step = 1'b1;
            end
         end
         ST_SKIP: begin
            if (sts.top_zero && !sts.cnt_one) begin
               cmd.skip_shift = 1'b1;
            end else if (sts.has_prefix) begin
               state_in = ST_PREFIX;
            end else begin
               state_in = ST_DIGITS;
            end
         end
         ST_PREFIX: begin
            if (sts.out_free) begin
               cmd.emit_prefix = 1'b1;
               state_in = sts.prefix_last ? ST_IDLE : ST_DIGITS;
            end
         end
         ST_DIGITS: begin
            if (sts.out_free) begin
               cmd.emit_digit = 1'b1;
               if (sts.cnt_one) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // new transactions only between texts
   assign req_stall = (state_ff != ST_IDLE);

   // checks
   `I2A_ASSERT(a_cmd_single, clock, reset, $onehot0(cmd), "more than one command at once")
   `I2A_ASSERT(a_last_digit_idle, clock, reset, (cmd.emit_digit && sts.cnt_one) |=> (state_ff == ST_IDLE), "no return to idle after final digit")

endmodule

/* hdl/i2a_dp.sv */
// datapath: digit register, bcd conversion, leading zero skip, output register
// depends on i2a_pkg and assert_macros.svh
`include "assert_macros.svh"

module i2a_dp
   import i2a_pkg::*;
#(
   parameter int unsigned VALUE_WIDTH = VALUE_WIDTH_DEF
)
(
   input  logic        clock,
   input  logic        reset,
   input  i2a_req_type req_data,
   input  i2a_cmd_type cmd,
   output i2a_sts_type sts,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output i2a_rsp_type rsp_data
);

   localparam int unsigned VW   = VALUE_WIDTH;
   localparam int unsigned NDIG = (VW + 2) / 3;
   localparam int unsigned DW   = NDIG * 4;
   localparam int unsigned OW   = NDIG * 3;
   localparam int unsigned CW   = $clog2(NDIG + 1);
   localparam int unsigned BW   = $clog2(VW + 1);

   logic [1:0]    op_ff;
   logic          neg_ff;
   logic          zero_ff;
   logic [VW-1:0] bin_ff,     bin_in;
   logic [DW-1:0] dig_ff,     dig_in;
   logic [CW-1:0] cnt_ff,     cnt_in;
   logic [BW-1:0] bit_cnt_ff, bit_cnt_in;
   logic          rsp_valid_ff;
   i2a_rsp_type   rsp_ff;

   logic [VW+31:0] val_wide;
   logic [VW-1:0]  val_ext;
   logic [VW-1:0]  mag;
   logic           neg;
   logic [DW+VW-1:0] hex_wide;
   logic [OW+VW-1:0] oct_wide;
   logic [OW-1:0]  oct_bits;
   logic [DW-1:0]  oct_dig;
   logic [DW-1:0]  adj;
   logic [3:0]     top_dig;
   logic           out_free;
   logic           emit;
   i2a_rsp_type    emit_rsp;

   // input value at conversion width, with sign handling
   assign val_wide = {{VW{1'b0}}, req_data.value};
   assign val_ext  = val_wide[VW-1:0];
   assign neg      = (req_data.op == OP_SDEC) && val_ext[VW-1];
   assign mag      = neg ? (~val_ext + 1'b1) : val_ext;

   // hex and octal digits come straight from the bits
   assign hex_wide = {{DW{1'b0}}, val_ext};
   assign oct_wide = {{OW{1'b0}}, val_ext};
   assign oct_bits = oct_wide[OW-1:0];

   for (genvar i = 0; i < NDIG; i++) begin : g_oct
      assign oct_dig[4*i +: 4] = {1'b0, oct_bits[3*i +: 3]};
   end

   // double dabble correction on every bcd digit
   always_comb begin
      logic [3:0] d;
      d   = '0;
      adj = '0;
      for (int i = 0; i < NDIG; i++) begin
         d = dig_ff[4*i +: 4];
         adj[4*i +: 4] = (d >= 4'd5) ? (d + 4'd3) : d;
      end
   end

   assign top_dig = dig_ff[DW-1 -: 4];

   // digit register, magnitude shifter and counters
   always_comb begin
      dig_in     = dig_ff;
      bin_in     = bin_ff;
      cnt_in     = cnt_ff;
      bit_cnt_in = bit_cnt_ff;
      if (cmd.load) begin
         bin_in = mag;
         cnt_in = CW'(NDIG);
         case (req_data.op)
            OP_HEX: begin
               dig_in     = hex_wide[DW-1:0];
               bit_cnt_in = '0;
            end
            OP_OCT: begin
               dig_in     = oct_dig;
               bit_cnt_in = '0;
            end
            default: begin
               dig_in     = '0;
               bit_cnt_in = BW'(VW);
            end
         endcase
      end else if (cmd.conv_step) begin
         dig_in     = {adj[DW-2:0], bin_ff[VW-1]};
         bin_in     = {bin_ff[VW-2:0], 1'b0};
         bit_cnt_in = bit_cnt_ff - 1'b1;
      end else if (cmd.skip_shift || cmd.emit_digit) begin
         dig_in = {dig_ff[DW-5:0], 4'b0000};
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      dig_ff     <= dig_in;
      bin_ff     <= bin_in;
      cnt_ff     <= cnt_in;
      bit_cnt_ff <= bit_cnt_in;
      if (cmd.load) begin
         op_ff   <= req_data.op;
         neg_ff  <= neg;
         zero_ff <= (val_ext == '0);
      end
   end

   // character selection for the next transaction
   always_comb begin
      emit_rsp = '0;
      if (cmd.emit_prefix) begin
         case (op_ff)
            OP_OCT:  emit_rsp.char_code = CHAR_ZERO;
            OP_HEX:  emit_rsp.char_code = CHAR_HASH;
            default: emit_rsp.char_code = CHAR_MINUS;
         endcase
         emit_rsp.last = sts.prefix_last;
      end else begin
         emit_rsp.char_code = digit_char(top_dig);
         emit_rsp.last      = (cnt_ff == CW'(1));
      end
   end

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign emit     = cmd.emit_prefix || cmd.emit_digit;

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_ff <= emit_rsp;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // status back to the controller
   assign sts.conv_done   = (bit_cnt_ff == '0);
   assign sts.top_zero    = (top_dig == 4'd0);
   assign sts.cnt_one     = (cnt_ff == CW'(1));
   assign sts.has_prefix  = (op_ff == OP_OCT) || (op_ff == OP_HEX) || neg_ff;
   assign sts.prefix_last = (op_ff == OP_OCT) && zero_ff;
   assign sts.out_free    = out_free;

   // checks
   `I2A_ASSERT_NEVER(a_digit_cnt_empty, clock, reset, (cmd.emit_digit || cmd.skip_shift) && (cnt_ff == '0), "digit shifted with no digit left")
   `I2A_ASSERT_NEVER(a_conv_overrun, clock, reset, cmd.conv_step && (bit_cnt_ff == '0), "conversion step past the last bit")
   `I2A_ASSERT(a_emit_valid, clock, reset, emit |=> rsp_valid_ff, "character emitted but output not valid")

endmodule

/* hdl/integer_to_ascii_radix_converter.sv */
// Integer to ASCII converter: each request transaction carries a mode (signed
// decimal, unsigned decimal, octal with a leading '0', hex with a leading '#')
// and a value; the block answers with one response transaction per character,
// most significant first, with last set on the final one. One request is
// worked at a time: after acceptance, decimal modes pass the value through the
// bit-serial binary to BCD shifter (one bit per cycle), while octal and hex
// load their digits straight from the bits; then leading zero digits are
// dropped from the digit register (at most (VALUE_WIDTH+2)/3-1 of them) and
// the characters enter the output register while the response side does not
// stall. A new request is taken on the cycle after the last character enters
// the output register. Depends on i2a_pkg, i2a_ctrl and i2a_dp.

module integer_to_ascii_radix_converter
   import i2a_pkg::*;
#(
   parameter int unsigned VALUE_WIDTH = VALUE_WIDTH_DEF
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  i2a_req_type req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output i2a_rsp_type rsp_data
);

   i2a_cmd_type cmd;
   i2a_sts_type sts;

   // sequencer
   i2a_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   // conversion datapath and output register
   i2a_dp #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule
